// ===== src/scs_pkg.sv =====
`default_nettype none

package scs_pkg;

   localparam int SCRIPT_DEPTH = 1024;
   localparam int PtrW = $clog2(SCRIPT_DEPTH);

   typedef logic [PtrW-1:0]   ptr_type;
   typedef logic signed [24:0] delay_type;

   localparam logic [23:0] DATA_NONE   = 24'hffffff;
   localparam logic [6:0]  FULL_VOLUME = 7'd100;
   localparam logic [2:0]  ATTEN_IDLE  = 3'd2;
   localparam logic [2:0]  ATTEN_MAX   = 3'd4;

   // request operations
   localparam logic [2:0] OP_WRITE       = 3'd0;
   localparam logic [2:0] OP_START       = 3'd1;
   localparam logic [2:0] OP_TICK        = 3'd2;
   localparam logic [2:0] OP_STOP        = 3'd3;
   localparam logic [2:0] OP_SILENT_STOP = 3'd4;

   // script opcodes
   localparam logic [7:0] CMD_PLAY   = 8'd1;
   localparam logic [7:0] CMD_WAIT   = 8'd2;
   localparam logic [7:0] CMD_REPEAT = 8'd4;
   localparam logic [7:0] CMD_LOOP   = 8'd5;
   localparam logic [7:0] CMD_DELAY  = 8'd6;
   localparam logic [7:0] CMD_RANDOM = 8'd7;
   localparam logic [7:0] CMD_VOLUME = 8'd8;
   localparam logic [7:0] CMD_ATTEN  = 8'd10;
   localparam logic [7:0] CMD_END    = 8'd11;

   // result events
   localparam logic [2:0] EV_NONE     = 3'd0;
   localparam logic [2:0] EV_PLAY     = 3'd1;
   localparam logic [2:0] EV_LOOPED   = 3'd2;
   localparam logic [2:0] EV_CUT      = 3'd3;
   localparam logic [2:0] EV_CUT_STOP = 3'd4;
   localparam logic [2:0] EV_ENDED    = 3'd5;

   // stop modes
   localparam logic [1:0] MODE_NONE = 2'd0;
   localparam logic [1:0] MODE_CUT  = 2'd1;

   // all-ones data reads as -1
   function automatic delay_type word_data(logic [23:0] data);
      delay_type d;
      if (data == DATA_NONE) begin
         d = -25'sd1;
      end else begin
         d = $signed({1'b0, data});
      end
      return d;
   endfunction

   function automatic ptr_type ptr_add(ptr_type p, logic [1:0] n);
      logic [PtrW:0] s;
      s = {1'b0, p} + (PtrW+1)'(n);
      if (s >= (PtrW+1)'(SCRIPT_DEPTH)) begin
         s = s - (PtrW+1)'(SCRIPT_DEPTH);
      end
      return s[PtrW-1:0];
   endfunction

   function automatic logic [2:0] end_event(logic silent, logic [1:0] mode);
      logic [2:0] ev;
      if (silent || mode == MODE_CUT) begin
         ev = EV_CUT;
      end else if (mode == MODE_NONE) begin
         ev = EV_ENDED;
      end else begin
         ev = EV_CUT_STOP;
      end
      return ev;
   endfunction

   // minimum plus remainder, saturated at the largest delay
   function automatic delay_type rand_delay(delay_type d, logic [7:0] rem);
      logic signed [25:0] v;
      v = $signed({d[24], d}) + $signed({18'd0, rem});
      if (v > $signed(26'h0ffffff)) begin
         v = $signed(26'h0ffffff);
      end
      return v[24:0];
   endfunction

endpackage

`default_nettype wire

// ===== src/sound_command_sequencer.sv =====
`default_nettype none

// Sound command sequencer: one channel that runs a script of 32-bit command
// words held in an internal single-port script RAM. Issue a request by raising
// start while busy is low; each request produces exactly one result, shown on
// the rsp_ ports for one cycle with rsp_strobe high, and the receiver cannot
// stall it. Script writes, starts, stops and ticks that only count a delay
// answer straight from the idle state. A tick that runs a command first reads
// the script RAM twice (the command word and the word after it) and then
// executes it. A random delay whose range is 1 to 255 also passes through the
// bit-serial remainder unit. busy stays high until the result shows.
module sound_command_sequencer (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output      logic                    busy,
   input  wire logic [2:0]              req_operation,
   input  wire logic [9:0]              req_address,
   input  wire logic [31:0]             req_script_word,
   input  wire logic [1:0]              req_stop_mode,
   input  wire logic [23:0]             req_stop_sound,
   input  wire logic                    req_sound_playing,
   input  wire logic [7:0]              req_random_value,
   output      logic                    rsp_strobe,
   output      logic [2:0]              rsp_event_res,
   output      logic [23:0]             rsp_sound_id,
   output      logic [6:0]              rsp_volume,
   output      logic [2:0]              rsp_attenuation,
   output      logic                    rsp_active
);
   import scs_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_W0   = 2'd1;
   localparam logic [1:0] S_EXEC = 2'd2;
   localparam logic [1:0] S_MOD  = 2'd3;

   logic [31:0] script_mem [SCRIPT_DEPTH];
   logic [31:0] rd_q_ff;
   logic        mem_we;
   logic        mem_re;
   ptr_type     rd_addr;
   ptr_type     wr_addr;

   logic [1:0]  state_ff, state_in;
   ptr_type     ptr_ff, ptr_in;
   delay_type   delay_ff, delay_in;
   logic [6:0]  vol_ff, vol_in;
   logic [2:0]  atten_ff, atten_in;
   logic [1:0]  mode_ff, mode_in;
   logic [23:0] ssnd_ff, ssnd_in;
   logic        running_ff, running_in;
   logic        strobe_ff, strobe_in;
   logic [2:0]  event_ff, event_in;
   logic [23:0] snd_ff, snd_in;
   logic        playing_ff, playing_in;
   logic [7:0]  rnd_ff, rnd_in;
   logic [31:0] w0_ff, w0_in;
   logic [7:0]  rem_ff, rem_in;
   logic [7:0]  div_ff, div_in;
   logic [2:0]  cnt_ff, cnt_in;

   logic        accept;
   logic [7:0]  opcode;
   delay_type   d0;
   delay_type   d1;
   logic signed [25:0] range;
   logic [8:0]  rem_sh;
   logic [7:0]  rem_step;
   logic [2:0]  stop_ev;

   assign accept  = start && (state_ff == S_IDLE);
   assign wr_addr = PtrW'(req_address % SCRIPT_DEPTH);
   assign opcode  = w0_ff[31:24];
   assign d0      = word_data(w0_ff[23:0]);
   assign d1      = word_data(rd_q_ff[23:0]);
   assign range   = $signed({d1[24], d1}) - $signed({d0[24], d0});
   assign rem_sh  = {rem_ff, rnd_ff[7]};
   assign rem_step = (rem_sh >= {1'b0, div_ff}) ? 8'(rem_sh - {1'b0, div_ff}) : rem_sh[7:0];

   always_comb begin
      state_in   = state_ff;
      ptr_in     = ptr_ff;
      delay_in   = delay_ff;
      vol_in     = vol_ff;
      atten_in   = atten_ff;
      mode_in    = mode_ff;
      ssnd_in    = ssnd_ff;
      running_in = running_ff;
      strobe_in  = 1'b0;
      event_in   = event_ff;
      snd_in     = snd_ff;
      playing_in = playing_ff;
      rnd_in     = rnd_ff;
      w0_in      = w0_ff;
      rem_in     = rem_ff;
      div_in     = div_ff;
      cnt_in     = cnt_ff;
      mem_we     = 1'b0;
      mem_re     = 1'b0;
      rd_addr    = ptr_ff;
      stop_ev    = end_event(1'b0, mode_ff);

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               strobe_in  = 1'b1;
               event_in   = EV_NONE;
               snd_in     = '0;
               playing_in = req_sound_playing;
               rnd_in     = req_random_value;
               unique case (req_operation) inside
                  OP_WRITE: begin
                     mem_we = 1'b1;
                  end
                  OP_START: begin
                     if (running_ff) begin
                        event_in = stop_ev;
                        snd_in   = (stop_ev == EV_CUT_STOP) ? ssnd_ff : '0;
                     end
                     ptr_in     = wr_addr;
                     delay_in   = '0;
                     mode_in    = req_stop_mode;
                     ssnd_in    = req_stop_sound;
                     vol_in     = FULL_VOLUME;
                     atten_in   = ATTEN_IDLE;
                     running_in = 1'b1;
                  end
                  OP_TICK: begin
                     if (running_ff) begin
                        if (delay_ff > 0) begin
                           delay_in = delay_ff - 25'sd1;
                        end else if (delay_ff < 0 && req_sound_playing) begin
                           delay_in = delay_ff + 25'sd1;
                        end else begin
                           // fetch the command word, result comes later
                           strobe_in = 1'b0;
                           mem_re    = 1'b1;
                           state_in  = S_W0;
                        end
                     end
                  end
                  OP_STOP, OP_SILENT_STOP: begin
                     if (running_ff) begin
                        stop_ev    = end_event(req_operation == OP_SILENT_STOP, mode_ff);
                        event_in   = stop_ev;
                        snd_in     = (stop_ev == EV_CUT_STOP) ? ssnd_ff : '0;
                        running_in = 1'b0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_W0: begin
            w0_in    = rd_q_ff;
            mem_re   = 1'b1;
            rd_addr  = ptr_add(ptr_ff, 2'd1);
            state_in = S_EXEC;
         end
         S_EXEC: begin
            strobe_in = 1'b1;
            state_in  = S_IDLE;
            event_in  = EV_NONE;
            snd_in    = '0;
            unique case (opcode)
               CMD_PLAY: begin
                  if (!playing_ff && !d0[24]) begin
                     event_in = EV_PLAY;
                     snd_in   = w0_ff[23:0];
                  end
                  ptr_in = ptr_add(ptr_ff, 2'd1);
               end
               CMD_WAIT: begin
                  if (!playing_ff) begin
                     ptr_in = ptr_add(ptr_ff, 2'd1);
                  end
               end
               CMD_REPEAT: begin
                  if (!playing_ff && !d0[24]) begin
                     event_in = EV_LOOPED;
                     snd_in   = w0_ff[23:0];
                  end
               end
               CMD_LOOP: begin
                  if (!d0[24]) begin
                     event_in = EV_LOOPED;
                     snd_in   = w0_ff[23:0];
                  end
                  delay_in = -d1;
               end
               CMD_DELAY: begin
                  delay_in = d0;
                  ptr_in   = ptr_add(ptr_ff, 2'd1);
               end
               CMD_RANDOM: begin
                  ptr_in = ptr_add(ptr_ff, 2'd2);
                  if (range > 26'sd255) begin
                     // the random byte is already below the range
                     delay_in = rand_delay(d0, rnd_ff);
                  end else if (range > 26'sd0) begin
                     strobe_in = 1'b0;
                     state_in  = S_MOD;
                     div_in    = range[7:0];
                     rem_in    = '0;
                     cnt_in    = '0;
                  end else begin
                     delay_in = d0;
                  end
               end
               CMD_VOLUME: begin
                  if (d0[24]) begin
                     vol_in = '0;
                  end else if (d0 > 25'sd100) begin
                     vol_in = FULL_VOLUME;
                  end else begin
                     vol_in = d0[6:0];
                  end
                  ptr_in = ptr_add(ptr_ff, 2'd1);
               end
               CMD_ATTEN: begin
                  if (!d0[24] && d0 <= $signed({22'd0, ATTEN_MAX})) begin
                     atten_in = d0[2:0];
                  end
                  ptr_in = ptr_add(ptr_ff, 2'd1);
               end
               CMD_END: begin
                  event_in   = stop_ev;
                  snd_in     = (stop_ev == EV_CUT_STOP) ? ssnd_ff : '0;
                  running_in = 1'b0;
               end
               default: begin
               end
            endcase
         end
         S_MOD: begin
            // one remainder bit per cycle, random byte MSB first
            rem_in = rem_step;
            rnd_in = {rnd_ff[6:0], 1'b0};
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd7) begin
               delay_in  = rand_delay(d0, rem_step);
               strobe_in = 1'b1;
               event_in  = EV_NONE;
               snd_in    = '0;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         script_mem[wr_addr] <= req_script_word;
      end
      if (mem_re) begin
         rd_q_ff <= script_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         ptr_ff     <= '0;
         delay_ff   <= '0;
         vol_ff     <= FULL_VOLUME;
         atten_ff   <= ATTEN_IDLE;
         mode_ff    <= MODE_NONE;
         ssnd_ff    <= '0;
         running_ff <= 1'b0;
         strobe_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         ptr_ff     <= ptr_in;
         delay_ff   <= delay_in;
         vol_ff     <= vol_in;
         atten_ff   <= atten_in;
         mode_ff    <= mode_in;
         ssnd_ff    <= ssnd_in;
         running_ff <= running_in;
         strobe_ff  <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      event_ff   <= event_in;
      snd_ff     <= snd_in;
      playing_ff <= playing_in;
      rnd_ff     <= rnd_in;
      w0_ff      <= w0_in;
      rem_ff     <= rem_in;
      div_ff     <= div_in;
      cnt_ff     <= cnt_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_strobe      = strobe_ff;
   assign rsp_event_res   = event_ff;
   assign rsp_sound_id    = snd_ff;
   assign rsp_volume      = vol_ff;
   assign rsp_attenuation = atten_ff;
   assign rsp_active      = running_ff;

endmodule

`default_nettype wire

// ===== src/scs_checker.sv =====
`default_nettype none

module scs_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic        rsp_strobe,
   input wire logic [2:0]  rsp_event_res,
   input wire logic [23:0] rsp_sound_id,
   input wire logic [6:0]  rsp_volume,
   input wire logic [2:0]  rsp_attenuation,
   input wire logic        rsp_active
);
   import scs_pkg::*;

   // an accepted request either occupies the block or completes next cycle
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_strobe))
      else $error("accepted request neither busy nor answered");

   a_result_when_free: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result shown while still busy");

   a_play_active: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_event_res == EV_PLAY || rsp_event_res == EV_LOOPED))
      |-> rsp_active)
      else $error("play event from an idle channel");

   a_no_sound: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_event_res == EV_NONE || rsp_event_res == EV_CUT ||
                      rsp_event_res == EV_ENDED)) |-> (rsp_sound_id == '0))
      else $error("sound id on an event that plays nothing");

   a_ranges: assert property (@(posedge clock) disable iff (reset)
      (rsp_volume <= FULL_VOLUME) && (rsp_attenuation <= ATTEN_MAX))
      else $error("volume or attenuation out of range");

endmodule

bind sound_command_sequencer scs_checker u_scs_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_strobe      (rsp_strobe),
   .rsp_event_res   (rsp_event_res),
   .rsp_sound_id    (rsp_sound_id),
   .rsp_volume      (rsp_volume),
   .rsp_attenuation (rsp_attenuation),
   .rsp_active      (rsp_active)
);

`default_nettype wire

// ===== dv/sequencer_checker.sv =====
module sequencer_checker
   import scs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [2:0]  req_operation,
   input  logic [9:0]  req_address,
   input  logic [31:0] req_script_word,
   input  logic [1:0]  req_stop_mode,
   input  logic [23:0] req_stop_sound,
   input  logic        req_sound_playing,
   input  logic [7:0]  req_random_value,
   input  logic        rsp_strobe,
   input  logic [2:0]  rsp_event_res,
   input  logic [23:0] rsp_sound_id,
   input  logic [6:0]  rsp_volume,
   input  logic [2:0]  rsp_attenuation,
   input  logic        rsp_active,
   output int          fail_count,
   output int          pending_count,
   output int          response_count
);

   localparam int DELAY_LIMIT = 24'hffffff;

   typedef struct packed {
      logic [2:0]  ev_code;
      logic [23:0] sound;
      logic [6:0]  level;
      logic [2:0]  atten;
      logic        active;
   } response_type;

   // shadow copy of the channel
   logic [31:0] script_words [SCRIPT_DEPTH];
   ptr_type     pointer;
   delay_type   delay;
   logic [23:0] current_sound;
   logic [6:0]  volume_level;
   logic [2:0]  atten_mode;
   logic [1:0]  held_mode;
   logic [23:0] held_stop_sound;
   logic        running;

   response_type outcome;
   response_type expected_responses [$];

   function automatic int data_value(logic [23:0] data);
      return (data == DATA_NONE) ? -1 : int'(data);
   endfunction

   function automatic ptr_type wrap_addr(int a);
      return ptr_type'(a % SCRIPT_DEPTH);
   endfunction

   function automatic void finish_sequence(logic silent);
      running = 1'b0;
      outcome.sound = '0;
      if (silent || held_mode == MODE_CUT) begin
         outcome.ev_code = EV_CUT;
      end else if (held_mode == MODE_NONE) begin
         outcome.ev_code = EV_ENDED;
      end else begin
         outcome.ev_code = EV_CUT_STOP;
         outcome.sound = held_stop_sound;
      end
   endfunction

   function automatic void play_sound(int d, logic [2:0] code);
      if (d < 0) begin
         current_sound = DATA_NONE;
      end else begin
         current_sound = 24'(d);
         outcome.ev_code = code;
         outcome.sound = current_sound;
      end
   endfunction

   function automatic response_type run_request(logic [2:0] op, logic [9:0] addr,
         logic [31:0] word, logic [1:0] mode, logic [23:0] stop_snd,
         logic playing, logic [7:0] rnd);
      logic [31:0] cmd;
      logic [31:0] follow;
      int d;
      int hi;
      int v;
      outcome = '0;
      case (op)
         OP_WRITE: script_words[addr] = word;
         OP_START: begin
            if (running) finish_sequence(1'b0);
            pointer = addr;
            delay = '0;
            held_mode = mode;
            held_stop_sound = stop_snd;
            current_sound = DATA_NONE;
            volume_level = FULL_VOLUME;
            atten_mode = ATTEN_IDLE;
            running = 1'b1;
         end
         OP_TICK: if (running) begin
            if (delay > 0) begin
               delay = delay - 1;
            end else if (delay < 0 && playing) begin
               delay = delay + 1;
            end else begin
               cmd = script_words[pointer];
               follow = script_words[wrap_addr(int'(pointer) + 1)];
               d = data_value(cmd[23:0]);
               hi = data_value(follow[23:0]);
               case (cmd[31:24])
                  CMD_PLAY: begin
                     if (!playing) play_sound(d, EV_PLAY);
                     pointer = wrap_addr(int'(pointer) + 1);
                  end
                  CMD_WAIT: if (!playing) begin
                     pointer = wrap_addr(int'(pointer) + 1);
                     current_sound = DATA_NONE;
                  end
                  CMD_REPEAT: if (!playing) play_sound(d, EV_LOOPED);
                  CMD_LOOP: begin
                     // pointer stays; the next word only gives the loop time
                     play_sound(d, EV_LOOPED);
                     delay = delay_type'(-hi);
                  end
                  CMD_DELAY: begin
                     delay = delay_type'(d);
                     pointer = wrap_addr(int'(pointer) + 1);
                     current_sound = DATA_NONE;
                  end
                  CMD_RANDOM: begin
                     // empty or negative range leaves the minimum
                     v = d;
                     if (hi > d) v = v + (int'(rnd) % (hi - d));
                     if (v > DELAY_LIMIT) v = DELAY_LIMIT;
                     delay = delay_type'(v);
                     pointer = wrap_addr(int'(pointer) + 2);
                     current_sound = DATA_NONE;
                  end
                  CMD_VOLUME: begin
                     if (d < 0) begin
                        volume_level = '0;
                     end else if (d > int'(FULL_VOLUME)) begin
                        volume_level = FULL_VOLUME;
                     end else begin
                        volume_level = 7'(d);
                     end
                     pointer = wrap_addr(int'(pointer) + 1);
                  end
                  CMD_ATTEN: begin
                     if (d >= 0 && d <= int'(ATTEN_MAX)) atten_mode = 3'(d);
                     pointer = wrap_addr(int'(pointer) + 1);
                  end
                  CMD_END: finish_sequence(1'b0);
                  default: ;
               endcase
            end
         end
         OP_STOP: if (running) finish_sequence(1'b0);
         OP_SILENT_STOP: if (running) finish_sequence(1'b1);
         default: ;
      endcase
      outcome.level = volume_level;
      outcome.atten = atten_mode;
      outcome.active = running;
      return outcome;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      response_type want;
      if (reset) begin
         pointer = '0;
         delay = '0;
         current_sound = DATA_NONE;
         volume_level = FULL_VOLUME;
         atten_mode = ATTEN_IDLE;
         held_mode = MODE_NONE;
         held_stop_sound = '0;
         running = 1'b0;
         expected_responses.delete();
         fail_count = 0;
         response_count = 0;
      end else begin
         // compare before queueing: a transfer's own response is registered, never in its accepting cycle
         if (rsp_strobe) begin
            response_count++;
            if (expected_responses.size() == 0) begin
               $display("%0t: response with none expected, expected nothing, got event %0d",
                        $time, rsp_event_res);
               fail_count++;
            end else begin
               want = expected_responses.pop_front();
               check_field("event", 32'(want.ev_code), 32'(rsp_event_res));
               check_field("sound_id", 32'(want.sound), 32'(rsp_sound_id));
               check_field("volume", 32'(want.level), 32'(rsp_volume));
               check_field("attenuation", 32'(want.atten), 32'(rsp_attenuation));
               check_field("active", 32'(want.active), 32'(rsp_active));
            end
         end
         if (start && !busy) begin
            expected_responses.push_back(run_request(req_operation, req_address,
               req_script_word, req_stop_mode, req_stop_sound, req_sound_playing,
               req_random_value));
         end
      end
      pending_count = expected_responses.size();
   end

endmodule

// ===== dv/tb.sv =====
module tb;
   import scs_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   // opcodes the block does not run
   localparam logic [7:0] CMD_NONE    = 8'd0;
   localparam logic [7:0] CMD_SPARE   = 8'd3;
   localparam logic [7:0] CMD_HOLD    = 8'd9;
   localparam logic [7:0] CMD_UNKNOWN = 8'd12;
   localparam logic [2:0] OP_SPARE    = 3'd7;
   localparam logic [1:0] MODE_CUT_STOP = 2'd2;
   localparam logic [1:0] MODE_ALIAS    = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_operation = '0;
   logic [9:0]  req_address = '0;
   logic [31:0] req_script_word = '0;
   logic [1:0]  req_stop_mode = '0;
   logic [23:0] req_stop_sound = '0;
   logic        req_sound_playing = 1'b0;
   logic [7:0]  req_random_value = '0;
   logic        rsp_strobe;
   logic [2:0]  rsp_event_res;
   logic [23:0] rsp_sound_id;
   logic [6:0]  rsp_volume;
   logic [2:0]  rsp_attenuation;
   logic        rsp_active;

   int fail_count;
   int pending_count;
   int response_count;
   int cycle_count;
   int idle_pct;
   int n_write, n_start, n_tick, n_stop, n_ignored;

   logic [31:0] script_plan [SCRIPT_DEPTH];

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   sound_command_sequencer dut (
      .clock, .reset, .start, .busy,
      .req_operation, .req_address, .req_script_word, .req_stop_mode,
      .req_stop_sound, .req_sound_playing, .req_random_value,
      .rsp_strobe, .rsp_event_res, .rsp_sound_id, .rsp_volume,
      .rsp_attenuation, .rsp_active
   );

   sequencer_checker seq_check (
      .clock, .reset, .start, .busy,
      .req_operation, .req_address, .req_script_word, .req_stop_mode,
      .req_stop_sound, .req_sound_playing, .req_random_value,
      .rsp_strobe, .rsp_event_res, .rsp_sound_id, .rsp_volume,
      .rsp_attenuation, .rsp_active,
      .fail_count, .pending_count, .response_count
   );

   // mostly well-formed commands with small delays, a few raw words
   function automatic logic [31:0] make_command();
      logic [23:0] sound;
      logic [23:0] data;
      logic [7:0]  opcode;
      sound = ($urandom_range(0, 19) == 0) ? DATA_NONE : 24'($urandom_range(0, 24'hfffffe));
      data = ($urandom_range(0, 19) == 0) ? DATA_NONE : 24'($urandom_range(0, 8));
      case ($urandom_range(0, 15))
         0, 1, 2: begin
            opcode = CMD_PLAY;
            data = sound;
         end
         3: opcode = CMD_WAIT;
         4: begin
            opcode = CMD_REPEAT;
            data = sound;
         end
         5: begin
            opcode = CMD_LOOP;
            data = sound;
         end
         6, 7: opcode = CMD_DELAY;
         8, 9: opcode = CMD_RANDOM;
         10, 11: begin
            opcode = CMD_VOLUME;
            if ($urandom_range(0, 1)) data = 24'($urandom_range(0, 160));
         end
         12: begin
            opcode = CMD_ATTEN;
            data = ($urandom_range(0, 9) == 0) ? DATA_NONE : 24'($urandom_range(0, 7));
         end
         13: opcode = CMD_END;
         14: begin
            case ($urandom_range(0, 3))
               0: opcode = CMD_NONE;
               1: opcode = CMD_SPARE;
               2: opcode = CMD_HOLD;
               default: opcode = 8'($urandom_range(CMD_UNKNOWN, 255));
            endcase
         end
         default: return $urandom();
      endcase
      return {opcode, data};
   endfunction

   // drive at the falling edge, hold until a rising edge sees busy low
   task automatic send_request(input logic [2:0] op, input logic [9:0] addr,
         input logic [31:0] word, input logic [1:0] mode, input logic [23:0] stop_snd,
         input logic playing, input logic [7:0] rnd);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_operation <= op;
      req_address <= addr;
      req_script_word <= word;
      req_stop_mode <= mode;
      req_stop_sound <= stop_snd;
      req_sound_playing <= playing;
      req_random_value <= rnd;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
      case (op) inside
         OP_WRITE: n_write++;
         OP_START: n_start++;
         OP_TICK: n_tick++;
         OP_STOP, OP_SILENT_STOP: n_stop++;
         default: n_ignored++;
      endcase
   endtask

   task automatic send_tick(input logic playing, input logic [7:0] rnd);
      send_request(OP_TICK, 10'($urandom), $urandom(), 2'($urandom),
                   24'($urandom_range(0, 24'hfffffe)), playing, rnd);
   endtask

   task automatic send_start(input logic [9:0] addr, input logic [1:0] mode,
         input logic [23:0] stop_snd);
      send_request(OP_START, addr, $urandom(), mode, stop_snd, 1'($urandom), 8'($urandom));
   endtask

   task automatic send_plain(input logic [2:0] op);
      send_request(op, 10'($urandom), $urandom(), 2'($urandom),
                   24'($urandom_range(0, 24'hfffffe)), 1'($urandom), 8'($urandom));
   endtask

   task automatic send_random_request();
      logic [2:0]  op;
      logic [31:0] word;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 6) op = OP_WRITE;
      else if (pick < 14) op = OP_START;
      else if (pick < 20) op = OP_STOP;
      else if (pick < 24) op = OP_SILENT_STOP;
      else if (pick < 26) op = 3'($urandom_range(OP_SILENT_STOP + 1, OP_SPARE));
      else op = OP_TICK;
      word = (op == OP_WRITE) ? make_command() : $urandom();
      send_request(op, 10'($urandom), word, 2'($urandom), 24'($urandom_range(0, 24'hfffffe)),
                   $urandom_range(0, 99) < 35, 8'($urandom));
   endtask

   // hold off until every expected response has arrived
   task automatic drain();
      start <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
   endtask

   task automatic run_phase(input int count, input int pct);
      idle_pct = pct;
      repeat (count) send_random_request();
      drain();
   endtask

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      idle_pct = 0;
      for (int a = 0; a < SCRIPT_DEPTH; a++) script_plan[a] = make_command();
      script_plan[1023] = {CMD_VOLUME, DATA_NONE};
      script_plan[0]    = {CMD_VOLUME, 24'd150};
      script_plan[1]    = {CMD_ATTEN, 24'd7};
      script_plan[2]    = {CMD_ATTEN, ATTEN_MAX};
      script_plan[3]    = {CMD_PLAY, DATA_NONE};
      script_plan[4]    = {CMD_PLAY, 24'hfffffe};
      script_plan[5]    = {CMD_RANDOM, 24'd3};
      script_plan[6]    = {CMD_DELAY, 24'd2};
      script_plan[7]    = {CMD_RANDOM, 24'd1};
      script_plan[8]    = {CMD_ATTEN, 24'd256};
      script_plan[9]    = {CMD_LOOP, 24'd5};
      script_plan[10]   = {CMD_DELAY, 24'd2};
      script_plan[11]   = {CMD_WAIT, 24'd0};
      script_plan[12]   = {CMD_UNKNOWN, 24'd0};
      script_plan[15]   = {CMD_REPEAT, DATA_NONE};
      script_plan[16]   = {CMD_RANDOM, 24'd0};
      script_plan[17]   = {CMD_PLAY, DATA_NONE};
      script_plan[18]   = {CMD_END, 24'd0};

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // load every word so no read ever hits an unwritten entry
      for (int a = 0; a < SCRIPT_DEPTH; a++) begin
         send_request(OP_WRITE, 10'(a), script_plan[a], 2'($urandom),
                      24'($urandom_range(0, 24'hfffffe)), 1'($urandom), 8'($urandom));
      end

      // top address wraps into the script at zero
      send_start(10'd1023, MODE_ALIAS, 24'hfffffe);
      repeat (6) send_tick(1'b0, 8'($urandom));
      send_tick(1'b0, 8'd0);
      send_tick(1'b0, 8'd0);
      send_tick(1'b1, 8'd0);
      send_tick(1'b0, 8'd0);
      send_tick(1'b0, 8'd255);
      send_tick(1'b0, 8'd0);
      send_tick(1'b0, 8'd0);
      send_tick(1'b1, 8'd0);
      // restart while running reports the old stop
      send_start(10'd16, MODE_CUT, 24'd0);
      send_tick(1'b0, 8'd255);
      send_tick(1'b0, 8'd0);
      send_tick(1'b1, 8'd0);
      send_plain(OP_SILENT_STOP);
      send_plain(OP_SPARE);
      send_start(10'd11, MODE_NONE, 24'd0);
      send_tick(1'b1, 8'd0);
      send_tick(1'b0, 8'd0);
      send_tick(1'b0, 8'd0);
      send_plain(OP_STOP);
      send_start(10'd15, MODE_CUT_STOP, 24'($urandom_range(0, 24'hfffffe)));
      send_tick(1'b0, 8'd0);
      send_plain(OP_SILENT_STOP);
      drain();

      run_phase(300, 33);
      run_phase(300, 86);
      run_phase(300, 0);
      repeat (12) @(negedge clock);

      $display("Sent %0d transfers: %0d writes, %0d starts, %0d ticks, %0d stops, %0d spare",
               n_write + n_start + n_tick + n_stop + n_ignored, n_write, n_start, n_tick,
               n_stop, n_ignored);
      $display("Compared %0d responses over three sender pacing profiles", response_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== sound_command_sequencer.f =====
src/scs_pkg.sv
src/sound_command_sequencer.sv
src/scs_checker.sv
dv/sequencer_checker.sv
dv/tb.sv
